FILE: design/fixed_schema_json_record_parser_top_macros.svh
// Assertion macros shared by the JSON record parser RTL.
`ifndef FIXED_SCHEMA_JSON_RECORD_PARSER_TOP_MACROS_SVH
`define FIXED_SCHEMA_JSON_RECORD_PARSER_TOP_MACROS_SVH

// Checks that a condition implies another in the same cycle.
`define FJP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fjp check failed");

// Checks that a condition implies another in the following cycle.
`define FJP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fjp check failed");

`endif

FILE: design/fjp_pkg.sv
// Shared types, codes and character helpers of the JSON record parser.
package fjp_pkg;

   localparam logic [2:0] EV_INT    = 3'd0;
   localparam logic [2:0] EV_CHAR   = 3'd1;
   localparam logic [2:0] EV_STREND = 3'd2;
   localparam logic [2:0] EV_BOOL   = 3'd3;
   localparam logic [2:0] EV_RECEND = 3'd4;
   localparam logic [2:0] EV_ARREND = 3'd5;
   localparam logic [2:0] EV_ERROR  = 3'd6;

   localparam logic [2:0] LAST_SLOT = 3'd6;

   localparam logic [1:0] VT_INT  = 2'd0;
   localparam logic [1:0] VT_STR  = 2'd1;
   localparam logic [1:0] VT_BOOL = 2'd2;

   typedef struct packed {
      logic [2:0]  kind;
      logic [2:0]  field;
      logic [63:0] int_value;
      logic [7:0]  char_value;
      logic        bool_value;
   } event_type;

   function automatic logic is_ws(input logic [7:0] c);
      return ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic [7:0] key_letter(input logic [2:0] slot);
      logic [7:0] r;
      case (slot)
         3'd0: r = 8'h61;
         3'd1: r = 8'h70;
         3'd2: r = 8'h71;
         3'd3: r = 8'h66;
         3'd4: r = 8'h6C;
         3'd5: r = 8'h54;
         3'd6: r = 8'h6D;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] key_kind(input logic [2:0] slot);
      logic [1:0] r;
      case (slot)
         3'd1, 3'd2: r = VT_STR;
         3'd6: r = VT_BOOL;
         default: r = VT_INT;
      endcase
      return r;
   endfunction

endpackage

FILE: design/fjp_in_reg.sv
// Input register that holds one accepted word until the parser takes it.
module fjp_in_reg
   import fjp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_stream_start,
   input  logic       take,
   output logic       held_valid,
   output logic [7:0] held_byte,
   output logic       held_start
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       start_ff;

   assign req_ready  = !valid_ff || take;
   assign valid_in   = (req_valid && req_ready) || (valid_ff && !take);
   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;
   assign held_start = start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         byte_ff  <= req_data_byte;
         start_ff <= req_stream_start;
      end
   end

endmodule

FILE: design/fjp_core.sv
// Parser state and the one-byte step that yields the next state and event.
module fjp_core
   import fjp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       stream_start,
   output logic       emit,
   output event_type  ev
);

   typedef enum logic [4:0] {
      PH_BRACKET, PH_FIRST, PH_OBJ, PH_KEYQ, PH_KEYCH, PH_COLON,
      PH_INT_START, PH_INT_DIGIT1, PH_INT_MORE, PH_STR_Q, PH_STR_CH,
      PH_BOOL, PH_SKIP, PH_SEP, PH_AFTER_REC, PH_DONE, PH_ERR
   } phase_type;

   phase_type   phase_ff, phase_in, cur_phase;
   logic [2:0]  slot_ff, slot_in, cur_slot;
   logic [63:0] acc_ff, acc_in, cur_acc;
   logic        minus_ff, minus_in, cur_minus;
   logic [1:0]  len_ff, len_in, cur_len;
   logic        match_ff, match_in, cur_match;
   logic [2:0]  skip_ff, skip_in, cur_skip;
   logic        ws;
   logic        dig;
   logic [63:0] acc_times_ten;
   logic [2:0]  skip_dec;

   always_comb begin
      if (stream_start) begin
         cur_phase = PH_BRACKET;
         cur_slot  = '0;
         cur_acc   = '0;
         cur_minus = 1'b0;
         cur_len   = '0;
         cur_match = 1'b0;
         cur_skip  = '0;
      end else begin
         cur_phase = phase_ff;
         cur_slot  = slot_ff;
         cur_acc   = acc_ff;
         cur_minus = minus_ff;
         cur_len   = len_ff;
         cur_match = match_ff;
         cur_skip  = skip_ff;
      end
   end

   assign ws  = is_ws(data_byte);
   assign dig = is_digit(data_byte);
   assign acc_times_ten = {cur_acc[60:0], 3'b000} + {cur_acc[62:0], 1'b0}
                          + {60'd0, data_byte[3:0]};
   assign skip_dec = (cur_skip != 3'd0) ? (cur_skip - 3'd1) : cur_skip;

   always_comb begin
      phase_in = cur_phase;
      slot_in  = cur_slot;
      acc_in   = cur_acc;
      minus_in = cur_minus;
      len_in   = cur_len;
      match_in = cur_match;
      skip_in  = cur_skip;
      emit     = 1'b0;
      ev       = '0;
      ev.field = cur_slot;
      unique case (cur_phase)
         PH_BRACKET: begin
            if (!ws) begin
               if (data_byte == 8'h5B) begin
                  phase_in = PH_FIRST;
               end else begin
                  phase_in = PH_ERR;
                  emit     = 1'b1;
                  ev.kind  = EV_ERROR;
               end
            end
         end
         PH_FIRST, PH_OBJ: begin
            if (!ws) begin
               if (data_byte == 8'h5D && cur_phase == PH_FIRST) begin
                  phase_in = PH_DONE;
                  emit     = 1'b1;
                  ev.kind  = EV_ARREND;
                  ev.field = 3'd0;
               end else if (data_byte == 8'h7B) begin
                  slot_in  = 3'd0;
                  phase_in = PH_KEYQ;
               end else begin
                  phase_in = PH_ERR;
                  emit     = 1'b1;
                  ev.kind  = EV_ERROR;
               end
            end
         end
         PH_KEYQ: begin
            if (!ws) begin
               if (data_byte == 8'h22) begin
                  len_in   = 2'd0;
                  match_in = 1'b0;
                  phase_in = PH_KEYCH;
               end else begin
                  phase_in = PH_ERR;
                  emit     = 1'b1;
                  ev.kind  = EV_ERROR;
               end
            end
         end
         PH_KEYCH: begin
            if (data_byte == 8'h22) begin
               if (cur_len == 2'd1 && cur_match) begin
                  phase_in = PH_COLON;
               end else begin
                  phase_in = PH_ERR;
                  emit     = 1'b1;
                  ev.kind  = EV_ERROR;
               end
            end else begin
               match_in = (cur_len == 2'd0) && (data_byte == key_letter(cur_slot));
               if (cur_len != 2'd3) begin
                  len_in = cur_len + 2'd1;
               end
            end
         end
         PH_COLON: begin
            if (!ws) begin
               if (data_byte != 8'h3A) begin
                  phase_in = PH_ERR;
                  emit     = 1'b1;
                  ev.kind  = EV_ERROR;
               end else begin
                  case (key_kind(cur_slot))
                     VT_INT:  phase_in = PH_INT_START;
                     VT_STR:  phase_in = PH_STR_Q;
                     default: phase_in = PH_BOOL;
                  endcase
               end
            end
         end
         PH_INT_START: begin
            if (!ws) begin
               minus_in = 1'b0;
               if (data_byte == 8'h2D) begin
                  minus_in = 1'b1;
                  phase_in = PH_INT_DIGIT1;
               end else if (dig) begin
                  acc_in   = {60'd0, data_byte[3:0]};
                  phase_in = PH_INT_MORE;
               end else begin
                  phase_in = PH_ERR;
                  emit     = 1'b1;
                  ev.kind  = EV_ERROR;
               end
            end
         end
         PH_INT_DIGIT1: begin
            if (dig) begin
               acc_in   = {60'd0, data_byte[3:0]};
               phase_in = PH_INT_MORE;
            end else begin
               phase_in = PH_ERR;
               emit     = 1'b1;
               ev.kind  = EV_ERROR;
            end
         end
         PH_INT_MORE: begin
            if (dig) begin
               acc_in = acc_times_ten;
            end else if (!ws && data_byte != 8'h2C) begin
               phase_in = PH_ERR;
               emit     = 1'b1;
               ev.kind  = EV_ERROR;
            end else begin
               emit         = 1'b1;
               ev.kind      = EV_INT;
               ev.int_value = cur_minus ? (64'd0 - cur_acc) : cur_acc;
               if (data_byte == 8'h2C) begin
                  slot_in  = cur_slot + 3'd1;
                  phase_in = PH_KEYQ;
               end else begin
                  phase_in = PH_SEP;
               end
            end
         end
         PH_STR_Q: begin
            if (!ws) begin
               if (data_byte == 8'h22) begin
                  phase_in = PH_STR_CH;
               end else begin
                  phase_in = PH_ERR;
                  emit     = 1'b1;
                  ev.kind  = EV_ERROR;
               end
            end
         end
         PH_STR_CH: begin
            emit = 1'b1;
            if (data_byte == 8'h22) begin
               phase_in = PH_SEP;
               ev.kind  = EV_STREND;
            end else begin
               ev.kind       = EV_CHAR;
               ev.char_value = data_byte;
            end
         end
         PH_BOOL: begin
            if (!ws) begin
               emit = 1'b1;
               if (data_byte == 8'h74) begin
                  skip_in       = 3'd3;
                  phase_in      = PH_SKIP;
                  ev.kind       = EV_BOOL;
                  ev.bool_value = 1'b1;
               end else if (data_byte == 8'h66) begin
                  skip_in  = 3'd4;
                  phase_in = PH_SKIP;
                  ev.kind  = EV_BOOL;
               end else begin
                  phase_in = PH_ERR;
                  ev.kind  = EV_ERROR;
               end
            end
         end
         PH_SKIP: begin
            skip_in = skip_dec;
            if (skip_dec == 3'd0) begin
               phase_in = PH_SEP;
            end
         end
         PH_SEP: begin
            if (!ws) begin
               if (cur_slot < LAST_SLOT && data_byte == 8'h2C) begin
                  slot_in  = cur_slot + 3'd1;
                  phase_in = PH_KEYQ;
               end else if (cur_slot == LAST_SLOT && data_byte == 8'h7D) begin
                  phase_in = PH_AFTER_REC;
                  emit     = 1'b1;
                  ev.kind  = EV_RECEND;
                  ev.field = LAST_SLOT;
               end else begin
                  phase_in = PH_ERR;
                  emit     = 1'b1;
                  ev.kind  = EV_ERROR;
               end
            end
         end
         PH_AFTER_REC: begin
            if (!ws) begin
               if (data_byte == 8'h2C) begin
                  phase_in = PH_OBJ;
               end else if (data_byte == 8'h5D) begin
                  phase_in = PH_DONE;
                  emit     = 1'b1;
                  ev.kind  = EV_ARREND;
                  ev.field = 3'd0;
               end else begin
                  phase_in = PH_ERR;
                  emit     = 1'b1;
                  ev.kind  = EV_ERROR;
               end
            end
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_ERR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BRACKET;
         slot_ff  <= '0;
         acc_ff   <= '0;
         minus_ff <= 1'b0;
         len_ff   <= '0;
         match_ff <= 1'b0;
         skip_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         slot_ff  <= slot_in;
         acc_ff   <= acc_in;
         minus_ff <= minus_in;
         len_ff   <= len_in;
         match_ff <= match_in;
         skip_ff  <= skip_in;
      end
   end

endmodule

FILE: design/fjp_out_reg.sv
// Result register that holds one event until the consumer takes it.
module fjp_out_reg
   import fjp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  event_type ev,
   output logic      can_load,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output event_type held_ev
);

   logic      valid_ff;
   logic      valid_in;
   event_type ev_ff;

   assign can_load  = !valid_ff || rsp_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign held_ev   = ev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         ev_ff <= ev;
      end
   end

endmodule

FILE: design/fixed_schema_json_record_parser_top.sv
// Top level of the fixed-schema JSON record parser.
// The parser takes one byte of a JSON array of seven-key objects per clock and gives at most
// one event word per byte: an integer, a string character, a string end, a boolean, a record
// end, an array end or an error. A byte passes through an input register and one parser step
// into the result register, and with a ready consumer one byte is taken in every cycle. The
// parser step advances only when the result register is free or being emptied, which is what
// holds back the input side.
module fixed_schema_json_record_parser_top
   import fjp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_stream_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_kind,
   output logic [2:0]  rsp_field_number,
   output logic signed [63:0] rsp_int_value,
   output logic [7:0]  rsp_char_value,
   output logic        rsp_bool_value
);

   logic      held_valid;
   logic [7:0] held_byte;
   logic      held_start;
   logic      can_load;
   logic      step;
   logic      emit;
   event_type step_ev;
   event_type out_ev;

   assign step = held_valid && can_load;

   fjp_in_reg u_in_reg (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_stream_start (req_stream_start),
      .take             (step),
      .held_valid       (held_valid),
      .held_byte        (held_byte),
      .held_start       (held_start)
   );

   fjp_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .data_byte    (held_byte),
      .stream_start (held_start),
      .emit         (emit),
      .ev           (step_ev)
   );

   fjp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step && emit),
      .ev        (step_ev),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .held_ev   (out_ev)
   );

   assign rsp_event_kind   = out_ev.kind;
   assign rsp_field_number = out_ev.field;
   assign rsp_int_value    = out_ev.int_value;
   assign rsp_char_value   = out_ev.char_value;
   assign rsp_bool_value   = out_ev.bool_value;

`include "fixed_schema_json_record_parser_top_macros.svh"

   `FJP_ASSERT_SAME(a_int_only_for_int, clock, reset, rsp_valid && rsp_event_kind != EV_INT, rsp_int_value == 64'sd0)
   `FJP_ASSERT_SAME(a_recend_field, clock, reset, rsp_valid && rsp_event_kind == EV_RECEND, rsp_field_number == LAST_SLOT)
   `FJP_ASSERT_SAME(a_char_in_string, clock, reset, rsp_valid && rsp_event_kind == EV_CHAR, rsp_field_number == 3'd1 || rsp_field_number == 3'd2)
   `FJP_ASSERT_SAME(a_stall_holds_input, clock, reset, !req_ready, held_valid && rsp_valid && !rsp_ready)

endmodule
